>>> rtl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AST_IMPLY(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);
`define AST_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);
`else
`define AST_IMPLY(label, clk, rst_n, cond, expr, msg)
`define AST_NEXT(label, clk, rst_n, cond, expr, msg)
`endif

`endif

>>> rtl/scrd_pkg.sv
`timescale 1ns / 1ps
package scrd_pkg;

  localparam int unsigned DefMaxPixels = 64000;
  localparam int unsigned DefQueueDepth = 2;

  // stream formats
  localparam logic [1:0] FMT_NIBBLE = 2'd0;
  localparam logic [1:0] FMT_RUN3   = 2'd1;
  localparam logic [1:0] FMT_OPCODE = 2'd2;

  // two-bit opcodes of the opcode format
  localparam logic [1:0] OP_LITERAL = 2'b00;
  localparam logic [1:0] OP_NOP     = 2'b01;
  localparam logic [1:0] OP_FILL    = 2'b10;
  localparam logic [1:0] OP_SKIP    = 2'b11;

  // configuration register indexes
  localparam logic [1:0] CFG_FORMAT      = 2'd0;
  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_CLEAR_KEY   = 2'd2;

  // one run of identical pixels, produced by one input byte
  typedef struct packed {
    logic [7:0]  color;
    logic [15:0] start;
    logic [5:0]  count;    // never zero
    logic        cel_end;  // last pixel of this run is the last of the cel
  } run_cmd_t;

endpackage

>>> rtl/sprite_cel_rle_decoder.sv
`timescale 1ns / 1ps
// Each byte's run is written into the run queue, and its pixels leave from the output register.
// Throughput: one pixel per clock while out_ready is high; a run holds the pixel stage
//   until its last pixel is taken, and the input stalls once the run queue is full
//   (QUEUE_DEPTH entries). Bytes with no pixels are taken one per clock while it has room.
// Reset (synchronous, active low): format 2, pixel_count 0, clear_key 0, position 0,
//   control phase, run queue and output register emptied.
`include "assert_macros.svh"
module sprite_cel_rle_decoder #(
  parameter int unsigned MAX_PIXELS  = scrd_pkg::DefMaxPixels,
  parameter int unsigned QUEUE_DEPTH = scrd_pkg::DefQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic        in_cel_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel,
  output logic [15:0] out_pixel_index,
  output logic        out_run_last,
  output logic        out_cel_done
);
  import scrd_pkg::*;

  localparam logic [15:0] MaxPix = 16'(MAX_PIXELS);

  logic [1:0]  format_r;
  logic [15:0] pixel_count_r;
  logic [7:0]  clear_key_r;
  logic [15:0] limit;

  logic        q_push, q_pop, q_full, q_empty;
  run_cmd_t    q_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r      <= FMT_OPCODE;
      pixel_count_r <= '0;
      clear_key_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT:      format_r      <= cfg_wdata[1:0];
        CFG_PIXEL_COUNT: pixel_count_r <= cfg_wdata;
        CFG_CLEAR_KEY:   clear_key_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign limit = (pixel_count_r < MaxPix) ? pixel_count_r : MaxPix;

  scrd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fmt          (format_r),
    .limit        (limit),
    .clear_key    (clear_key_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .in_cel_start (in_cel_start),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  scrd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  scrd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_pixel_index (out_pixel_index),
    .out_run_last    (out_run_last),
    .out_cel_done    (out_cel_done)
  );

  `AST_IMPLY(a_push_not_full, clk, rst_n, q_push, !q_full, "run pushed into full queue")
  `AST_IMPLY(a_head_count, clk, rst_n, !q_empty, q_head.count != 6'd0, "queued run is empty")
  `AST_IMPLY(a_done_is_last, clk, rst_n, out_valid && out_cel_done, out_run_last, "cel end inside a run")
  `AST_IMPLY(a_done_index, clk, rst_n, out_valid && out_cel_done, out_pixel_index + 16'd1 == limit, "cel end at wrong index")

endmodule

>>> rtl/scrd_front.sv
`timescale 1ns / 1ps
module scrd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         fmt,
  input  logic [15:0]        limit,
  input  logic [7:0]         clear_key,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_code_byte,
  input  logic               in_cel_start,
  input  logic               q_full,
  output logic               q_push,
  output scrd_pkg::run_cmd_t q_cmd
);
  import scrd_pkg::*;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_LITERAL,
    PH_FILL
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [5:0]  run_left_r, run_left_nxt, left_eff, left_dec;
  logic [15:0] position_r, position_nxt, pos_eff, avail;
  logic [5:0]  len, n;
  logic [7:0]  color;
  logic        accept, active;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_eff   = in_cel_start ? '0 : position_r;
    phase_eff = in_cel_start ? PH_CONTROL : phase_r;
    left_eff  = in_cel_start ? '0 : run_left_r;
    left_dec  = left_eff - 6'd1;
    active    = pos_eff < limit;
    avail     = limit - pos_eff;

    len          = '0;
    color        = in_code_byte;
    phase_nxt    = PH_CONTROL;
    run_left_nxt = '0;

    case (fmt)
      FMT_NIBBLE: begin
        len   = {2'b00, in_code_byte[7:4]};
        color = {4'h0, in_code_byte[3:0]};
      end
      FMT_RUN3: begin
        if (in_code_byte[2:0] != 3'd0) begin
          len   = {3'b000, in_code_byte[2:0]};
          color = {3'b000, in_code_byte[7:3]};
        end else begin
          len   = {1'b0, in_code_byte[7:3]};
          color = clear_key;
        end
      end
      default: begin
        case (phase_eff)
          PH_LITERAL: begin
            len          = 6'd1;
            run_left_nxt = left_dec;
            phase_nxt    = (left_dec == 6'd0) ? PH_CONTROL : PH_LITERAL;
          end
          PH_FILL: begin
            len = left_eff;
          end
          default: begin
            case (in_code_byte[7:6])
              OP_LITERAL: begin
                if (in_code_byte[5:0] != 6'd0) begin
                  phase_nxt    = PH_LITERAL;
                  run_left_nxt = in_code_byte[5:0];
                end
              end
              OP_FILL: begin
                phase_nxt    = PH_FILL;
                run_left_nxt = in_code_byte[5:0];
              end
              OP_SKIP: begin
                len   = in_code_byte[5:0];
                color = clear_key;
              end
              OP_NOP: begin
              end
              default: begin
              end
            endcase
          end
        endcase
      end
    endcase

    // cut the run at the end of the cel
    n            = (avail < {10'd0, len}) ? avail[5:0] : len;
    position_nxt = pos_eff + {10'd0, n};

    q_push        = accept && active && (n != 6'd0);
    q_cmd.color   = color;
    q_cmd.start   = pos_eff;
    q_cmd.count   = n;
    q_cmd.cel_end = (position_nxt == limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CONTROL;
      run_left_r <= '0;
      position_r <= '0;
    end else if (accept) begin
      if (active) begin
        phase_r    <= phase_nxt;
        run_left_r <= run_left_nxt;
        position_r <= position_nxt;
      end else begin
        // finished cel: only a cel start changes anything
        phase_r    <= phase_eff;
        run_left_r <= left_eff;
        position_r <= pos_eff;
      end
    end
  end

endmodule

>>> rtl/scrd_fifo.sv
`timescale 1ns / 1ps
module scrd_fifo #(
  parameter int unsigned DEPTH = scrd_pkg::DefQueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scrd_pkg::run_cmd_t push_cmd,
  input  logic               pop,
  output scrd_pkg::run_cmd_t head_cmd,
  output logic               full,
  output logic               empty
);
  import scrd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_cmd_t        slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/scrd_back.sv
`timescale 1ns / 1ps
module scrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  scrd_pkg::run_cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pixel,
  output logic [15:0]        out_pixel_index,
  output logic               out_run_last,
  output logic               out_cel_done
);
  import scrd_pkg::*;

  logic [5:0]  k_r;
  logic        out_valid_r;
  logic [7:0]  pixel_r;
  logic [15:0] index_r;
  logic        run_last_r, cel_done_r;
  logic        advance, fire, last;

  assign advance = !out_valid_r || out_ready;
  assign fire    = advance && !q_empty;
  assign last    = (k_r + 6'd1 == q_head.count);
  assign q_pop   = fire && last;

  assign out_valid       = out_valid_r;
  assign out_pixel       = pixel_r;
  assign out_pixel_index = index_r;
  assign out_run_last    = run_last_r;
  assign out_cel_done    = cel_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        k_r         <= last ? '0 : k_r + 6'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload loads each time a pixel of the head run is issued
  always_ff @(posedge clk) begin
    if (fire) begin
      pixel_r    <= q_head.color;
      index_r    <= q_head.start + {10'd0, k_r};
      run_last_r <= last;
      cel_done_r <= last && q_head.cel_end;
    end
  end

endmodule

>>> verif/tb_sprite_cel_rle_decoder.sv
`timescale 1ns / 1ps
module tb_sprite_cel_rle_decoder;
  import scrd_pkg::*;

  localparam int unsigned CEL_MAX = DefMaxPixels;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [1:0] FMT_OPCODE_ALT = 2'd3;  // decodes like the opcode format
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {PH_CONTROL, PH_LITERAL, PH_FILL} dec_phase_t;

  typedef struct packed {
    logic [7:0]  color;
    logic [15:0] index;
    logic        last;
    logic        done;
  } pixel_t;

  typedef struct packed {
    logic [7:0] code;
    logic       start;
  } code_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_code_byte = '0;
  logic        in_cel_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel;
  logic [15:0] out_pixel_index;
  logic        out_run_last;
  logic        out_cel_done;

  sprite_cel_rle_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_byte   (in_code_byte),
    .in_cel_start   (in_cel_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_pixel_index(out_pixel_index),
    .out_run_last   (out_run_last),
    .out_cel_done   (out_cel_done)
  );

  // register copies and decoder state
  logic [1:0]  cfg_format = FMT_OPCODE;
  logic [15:0] cfg_pixel_count = '0;
  logic [7:0]  cfg_clear_key = '0;
  dec_phase_t  dec_phase = PH_CONTROL;
  logic [5:0]  dec_run_left = '0;
  int          cel_pos = 0;

  code_t  pending_codes[$];
  pixel_t expected_pixels[$];
  int     tx_idle = 26;
  int     rx_idle = 55;
  int     err_count = 0;
  int     cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] op_byte(input logic [1:0] op, input logic [5:0] len);
    return {op, len};
  endfunction

  function automatic int cel_limit();
    return (cfg_pixel_count < CEL_MAX) ? int'(cfg_pixel_count) : int'(CEL_MAX);
  endfunction

  function automatic int emit_pixels(input logic [7:0] color, input int len);
    int limit;
    int n;
    pixel_t px;
    limit = cel_limit();
    n = 0;
    while (n < len && cel_pos < limit) begin
      px.color = color;
      px.index = cel_pos[15:0];
      px.last  = 1'b0;
      px.done  = (cel_pos + 1 == limit);
      expected_pixels.push_back(px);
      cel_pos++;
      n++;
    end
    return n;
  endfunction

  function automatic void decode_byte(input logic [7:0] code, input logic start);
    int n;
    n = 0;
    if (start) begin
      cel_pos = 0;
      dec_phase = PH_CONTROL;
      dec_run_left = '0;
    end
    if (cel_pos >= cel_limit()) return;
    if (cfg_format == FMT_NIBBLE) begin
      dec_phase = PH_CONTROL;
      dec_run_left = '0;
      n = emit_pixels({4'h0, code[3:0]}, code[7:4]);
    end else if (cfg_format == FMT_RUN3) begin
      dec_phase = PH_CONTROL;
      dec_run_left = '0;
      if (code[2:0] != 3'd0) n = emit_pixels({3'b000, code[7:3]}, code[2:0]);
      else n = emit_pixels(cfg_clear_key, code[7:3]);
    end else if (dec_phase == PH_LITERAL) begin
      n = emit_pixels(code, 1);
      dec_run_left = dec_run_left - 6'd1;
      if (dec_run_left == 6'd0) dec_phase = PH_CONTROL;
    end else if (dec_phase == PH_FILL) begin
      n = emit_pixels(code, dec_run_left);
      dec_run_left = '0;
      dec_phase = PH_CONTROL;
    end else begin
      case (code[7:6])
        OP_LITERAL: begin
          if (code[5:0] != 6'd0) begin
            dec_phase = PH_LITERAL;
            dec_run_left = code[5:0];
          end
        end
        OP_FILL: begin
          dec_phase = PH_FILL;
          dec_run_left = code[5:0];
        end
        OP_SKIP: n = emit_pixels(cfg_clear_key, code[5:0]);
        default: ;
      endcase
    end
    if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
  endfunction

  function automatic void push_code(input logic [7:0] code, input logic start);
    code_t c;
    c.code = code;
    c.start = start;
    pending_codes.push_back(c);
  endfunction

  // wait until every byte is taken and every pixel is out, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    while (pending_codes.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FORMAT:      cfg_format = val[1:0];
      CFG_PIXEL_COUNT: cfg_pixel_count = val;
      CFG_CLEAR_KEY:   cfg_clear_key = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [5:0] run_len();
    return ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(10));
  endfunction

  // mostly well-formed operations for the current format, some noise and cut-off cels
  task automatic gen_cels(input int n_items);
    int made;
    int kind;
    logic start;
    logic [5:0] len;
    made = 0;
    while (made < n_items) begin
      start = (made == 0) || ($urandom_range(99) < 8);
      if (cfg_format == FMT_NIBBLE || cfg_format == FMT_RUN3) begin
        push_code(8'($urandom_range(255)), start);
        made++;
      end else begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          len = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 6));
          push_code(op_byte(OP_LITERAL, len), start);
          made++;
          for (int i = 0; i < len; i++) begin
            push_code(8'($urandom_range(255)), 1'b0);
            made++;
          end
        end else if (kind < 55) begin
          push_code(op_byte(OP_FILL, run_len()), start);
          push_code(8'($urandom_range(255)), 1'b0);
          made += 2;
        end else if (kind < 75) begin
          push_code(op_byte(OP_SKIP, run_len()), start);
          made++;
        end else if (kind < 85) begin
          push_code(op_byte(OP_NOP, 6'($urandom_range(63))), start);
          made++;
        end else begin
          push_code(8'($urandom_range(255)), start);
          made++;
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    code_t next_code;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_code_byte, in_cel_start);
      if (!in_valid || in_ready) begin
        if (pending_codes.size() != 0 && $urandom_range(99) >= tx_idle) begin
          next_code = pending_codes.pop_front();
          in_valid <= 1'b1;
          in_code_byte <= next_code.code;
          in_cel_start <= next_code.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    out_ready <= rst_n && ($urandom_range(99) >= rx_idle);
    if (rst_n && out_valid && out_ready) begin
      got = {out_pixel, out_pixel_index, out_run_last, out_cel_done};
      if (expected_pixels.size() == 0) begin
        err_count++;
        $display("%0t: no pixel expected, got color %h index %0d last %b done %b",
                 $time, got.color, got.index, got.last, got.done);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          err_count++;
          $display({"%0t: expected color %h index %0d last %b done %b, ",
                    "got color %h index %0d last %b done %b"},
                   $time, want.color, want.index, want.last, want.done,
                   got.color, got.index, got.last, got.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // cel size is still zero after reset: nothing comes out
    @(negedge clk);
    push_code(8'hFF, 1'b1);
    push_code(op_byte(OP_SKIP, 6'd5), 1'b0);
    settle();

    write_reg(CFG_FORMAT, 16'(FMT_OPCODE));
    write_reg(CFG_PIXEL_COUNT, 16'd20);
    write_reg(CFG_CLEAR_KEY, 16'h00A5);
    @(negedge clk);
    push_code(op_byte(OP_LITERAL, 6'd3), 1'b1);
    push_code(8'h00, 1'b0);
    push_code(8'hFF, 1'b0);
    push_code(8'h7E, 1'b0);
    push_code(op_byte(OP_LITERAL, 6'd0), 1'b0);
    push_code(op_byte(OP_NOP, 6'h3F), 1'b0);
    push_code(op_byte(OP_FILL, 6'd0), 1'b0);
    push_code(8'h12, 1'b0);
    push_code(op_byte(OP_FILL, 6'd5), 1'b0);
    push_code(8'hFF, 1'b0);
    push_code(op_byte(OP_SKIP, 6'd0), 1'b0);
    push_code(op_byte(OP_SKIP, 6'd4), 1'b0);
    // fill runs past the cel end and is cut; the next byte is dropped
    push_code(op_byte(OP_FILL, 6'h3F), 1'b0);
    push_code(8'h33, 1'b0);
    push_code(8'hFF, 1'b0);
    // leave a fill pending, then switch format under it
    push_code(op_byte(OP_FILL, 6'd2), 1'b1);
    settle();

    write_reg(CFG_FORMAT, 16'(FMT_NIBBLE));
    @(negedge clk);
    push_code(8'h3C, 1'b0);
    push_code(8'h00, 1'b0);
    push_code(8'hFF, 1'b0);
    push_code(8'hF0, 1'b0);
    settle();

    write_reg(CFG_FORMAT, 16'(FMT_RUN3));
    write_reg(CFG_PIXEL_COUNT, 16'd100);
    @(negedge clk);
    push_code(8'h00, 1'b1);
    push_code(8'hF8, 1'b0);
    push_code(8'hFF, 1'b0);
    push_code(8'h07, 1'b0);
    settle();

    write_reg(CFG_FORMAT, 16'(FMT_OPCODE_ALT));
    write_reg(CFG_SPARE, 16'hFFFF);
    @(negedge clk);
    push_code(op_byte(OP_SKIP, 6'd2), 1'b1);
    push_code(op_byte(OP_LITERAL, 6'd5), 1'b0);
    settle();

    write_reg(CFG_FORMAT, 16'(FMT_RUN3));
    @(negedge clk);
    push_code(8'h0B, 1'b0);

    for (int seg = 0; seg < 9; seg++) begin
      int pick;
      settle();
      pick = $urandom_range(9);
      if (pick < 2) write_reg(CFG_FORMAT, 16'(FMT_NIBBLE));
      else if (pick < 4) write_reg(CFG_FORMAT, 16'(FMT_RUN3));
      else if (pick < 9) write_reg(CFG_FORMAT, 16'(FMT_OPCODE));
      else write_reg(CFG_FORMAT, 16'(FMT_OPCODE_ALT));
      if ($urandom_range(9) == 0) write_reg(CFG_PIXEL_COUNT, 16'($urandom_range(3)));
      else write_reg(CFG_PIXEL_COUNT, 16'($urandom_range(8, 150)));
      write_reg(CFG_CLEAR_KEY, (seg == 0) ? 16'd0 : 16'($urandom_range(255)));
      @(negedge clk);
      if (seg == 3) begin
        tx_idle = 55;
        rx_idle = 26;
      end else if (seg == 6) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      gen_cels($urandom_range(6, 10));
    end

    // largest cel size: the count is clipped to the maximum
    settle();
    write_reg(CFG_FORMAT, 16'(FMT_OPCODE));
    write_reg(CFG_PIXEL_COUNT, 16'hFFFF);
    write_reg(CFG_CLEAR_KEY, 16'h00FF);
    @(negedge clk);
    for (int i = 0; i < 3; i++) push_code(op_byte(OP_SKIP, 6'h3F), i == 0);
    push_code(op_byte(OP_FILL, 6'd4), 1'b0);
    push_code(8'h5A, 1'b0);

    settle();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
